@@ sv/rph_pkg.sv @@
// Shared definitions for the rescaled pixel histogram: command and register codes,
// default sizes and the control structs between the sequencer and the bin store.
// No dependencies.
`default_nettype none

package rph_pkg;

  // Default sizes for the top-level parameters.
  localparam int BIN_ADDR_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF    = 32;

  // Field widths of the configuration registers and items.
  localparam int MODE_W      = 2;
  localparam int SBITS_W     = 5;
  localparam int SLOPE_W     = 24;
  localparam int ICEPT_W     = 16;
  localparam int OFFSET_W    = 15;
  localparam int CMD_W       = 2;
  localparam int SAMPLE_W    = 17;
  localparam int SELECT_W    = 16;
  localparam int VALUE_W     = 32;
  localparam int USED_W      = 16;
  localparam int TOTAL_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  // Command codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Pixel modes.
  localparam logic [MODE_W-1:0] MODE_BYTE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNSIGN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGNED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_Q16    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_OFFSET = 3'd4;

  // Bin-count exponent limits.
  localparam logic [SBITS_W-1:0] SBITS_MIN   = 5'd9;
  localparam logic [SBITS_W-1:0] SBITS_MAX   = 5'd16;
  localparam logic [SBITS_W-1:0] SBITS_FIXED = 5'd12;
  localparam logic [SBITS_W-1:0] SBITS_RESET = 5'd12;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 24'h010000;

  // Operations the sequencer hands to the bin store.
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_COUNT,
    OP_READ
  } st_kind_t;

  typedef struct packed {
    logic     valid;
    st_kind_t kind;
  } st_op_t;

  typedef struct packed {
    logic ready;
    logic done;
  } st_rsp_t;

endpackage

`default_nettype wire

@@ sv/rph_rescale.sv @@
// Three-stage pipeline that maps one sample to its histogram bin.
// Depends on rph_pkg.
`default_nettype none

module rph_rescale #(
  parameter int BIN_ADDR_BITS = rph_pkg::BIN_ADDR_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  [rph_pkg::MODE_W-1:0]          pixel_mode,
  input  wire  [rph_pkg::SBITS_W-1:0]         stored_bits,
  input  wire  signed [rph_pkg::SLOPE_W-1:0]  slope_q16,
  input  wire  signed [rph_pkg::ICEPT_W-1:0]  intercept,
  input  wire  [rph_pkg::OFFSET_W-1:0]        value_offset,
  input  wire                                 in_vld,
  input  wire  [rph_pkg::SAMPLE_W-1:0]        sample,
  output logic                                out_vld,
  output logic [BIN_ADDR_BITS-1:0]            out_bin
);

  localparam int PROD_W = rph_pkg::SAMPLE_W + rph_pkg::SLOPE_W;
  localparam int OFS_W  = rph_pkg::USED_W + 2;
  localparam int SUM_W  = PROD_W + 1;
  localparam int IDX_W  = SUM_W - 16;

  logic signed [rph_pkg::SAMPLE_W-1:0] s_val;
  logic signed [OFS_W-1:0]             ofs_val;
  logic [rph_pkg::SBITS_W-1:0]         bits_val;
  logic                                wide_val;

  logic                        vld1_r, vld2_r, vld3_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [OFS_W-1:0]     ofs_r;
  logic [7:0]                  byte1_r, byte2_r;
  logic                        wide1_r, wide2_r;
  logic [rph_pkg::SBITS_W-1:0] bits1_r, bits2_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic [BIN_ADDR_BITS-1:0]    bin_r;

  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         mask;
  logic [BIN_ADDR_BITS-1:0] bin_nxt;

  // Stage one inputs: sample view, combined offset and the effective bin-count exponent.
  always_comb begin
    wide_val = (pixel_mode == rph_pkg::MODE_UNSIGN) || (pixel_mode == rph_pkg::MODE_SIGNED);
    if (pixel_mode == rph_pkg::MODE_SIGNED) begin
      s_val = {sample[15], sample[15:0]};
    end else begin
      s_val = {1'b0, sample[15:0]};
    end
    ofs_val = OFS_W'(intercept) + signed'(OFS_W'(value_offset));
    bits_val = stored_bits;
    if (bits_val < rph_pkg::SBITS_MIN) begin
      bits_val = rph_pkg::SBITS_MIN;
    end
    if (bits_val > rph_pkg::SBITS_MAX) begin
      bits_val = rph_pkg::SBITS_MAX;
    end
    if ((pixel_mode == rph_pkg::MODE_SIGNED) && (value_offset != '0)) begin
      bits_val = rph_pkg::SBITS_FIXED;
    end
    if (bits_val > rph_pkg::SBITS_W'(BIN_ADDR_BITS)) begin
      bits_val = rph_pkg::SBITS_W'(BIN_ADDR_BITS);
    end
  end

  // Final stage: byte mode takes the low byte; otherwise floor, negative to zero, clamp to the top bin.
  always_comb begin
    idx  = sum_r[SUM_W-1:16];
    mask = (IDX_W'(1) << bits2_r) - IDX_W'(1);
    if (!wide2_r) begin
      bin_nxt = BIN_ADDR_BITS'(byte2_r);
    end else if (sum_r[SUM_W-1]) begin
      bin_nxt = '0;
    end else if ((idx & ~mask) != '0) begin
      bin_nxt = mask[BIN_ADDR_BITS-1:0];
    end else begin
      bin_nxt = idx[BIN_ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= s_val * slope_q16;
    ofs_r   <= ofs_val;
    byte1_r <= sample[7:0];
    wide1_r <= wide_val;
    bits1_r <= bits_val;
    sum_r   <= SUM_W'(prod_r) + SUM_W'(signed'({ofs_r, 16'b0}));
    byte2_r <= byte1_r;
    wide2_r <= wide1_r;
    bits2_r <= bits1_r;
    bin_r   <= bin_nxt;
  end

  assign out_vld = vld3_r;
  assign out_bin = bin_r;

endmodule

`default_nettype wire

@@ sv/rph_store.sv @@
// Bin memory with reads, read-modify-write for counting and a sweep that zeroes every bin.
// Depends on rph_pkg.
`default_nettype none

module rph_store #(
  parameter int BIN_ADDR_BITS = rph_pkg::BIN_ADDR_BITS_DEF,
  parameter int COUNT_BITS    = rph_pkg::COUNT_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  rph_pkg::st_op_t        op,
  input  wire  [BIN_ADDR_BITS-1:0]     op_addr,
  output rph_pkg::st_rsp_t             rsp,
  output logic [COUNT_BITS-1:0]        rd_data
);

  localparam int DEPTH = 1 << BIN_ADDR_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WB,
    S_CLR
  } state_t;

  state_t                   state_r;
  logic [BIN_ADDR_BITS-1:0] clr_addr_r;
  logic [BIN_ADDR_BITS-1:0] addr_r;
  rph_pkg::st_kind_t        kind_r;
  logic [COUNT_BITS-1:0]    rd_data_r;
  logic [COUNT_BITS-1:0]    mem [DEPTH];

  logic                     rd_en;
  logic                     wr_en;
  logic [BIN_ADDR_BITS-1:0] wr_addr;
  logic [COUNT_BITS-1:0]    wr_data;

  always_comb begin
    rd_en   = (state_r == S_IDLE) && op.valid && (op.kind != rph_pkg::OP_CLEAR);
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
    if ((state_r == S_WB) && (kind_r == rph_pkg::OP_COUNT)) begin
      wr_en = 1'b1;
    end else if (state_r == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[op_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_r <= op_addr;
      kind_r <= op.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (op.valid) begin
            state_r    <= (op.kind == rph_pkg::OP_CLEAR) ? S_CLR : S_WB;
            clr_addr_r <= '0;
          end
        end
        S_WB: begin
          state_r <= S_IDLE;
        end
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The sweep ends by itself at the last bin; a read or count finishes in S_WB.
  assign rsp.ready = (state_r == S_IDLE);
  assign rsp.done  = (state_r == S_WB) || ((state_r == S_CLR) && (clr_addr_r == '1));
  assign rd_data   = rd_data_r;

endmodule

`default_nettype wire

@@ sv/rescaled_pixel_histogram.sv @@
// Rescaled pixel histogram top level: item sequencer, configuration registers, output stage.
// One item is in work at a time, so the next item is taken only after the result is loaded
// into the output register. Reset (rst_n low, synchronous) loads register defaults, then
// zeroes all bins in a sweep during which in_tready stays low. Depends on rph_pkg.
`default_nettype none

module rescaled_pixel_histogram #(
  parameter int BIN_ADDR_BITS = rph_pkg::BIN_ADDR_BITS_DEF,
  parameter int COUNT_BITS    = rph_pkg::COUNT_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // Input item stream.
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [rph_pkg::IN_TDATA_W-1:0]    in_tdata,  // cmd[1:0], sample[18:2], bin_select[34:19]
  // Result item stream.
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [rph_pkg::OUT_TDATA_W-1:0]   out_tdata, // bin_value[31:0], bin_used[47:32],
                                                       // sample_total[79:48]
  // Configuration writes.
  input  wire                               cfg_we,
  input  wire  [rph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [rph_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // The sequencer waits in T_RESC for the bin pipeline, in T_STORE for the memory,
  // and in T_EMIT until the output register is free.
  typedef enum logic [1:0] {
    T_IDLE,
    T_RESC,
    T_STORE,
    T_EMIT
  } tstate_t;

  tstate_t tstate_r;

  // Configuration registers.
  logic [rph_pkg::MODE_W-1:0]         pixel_mode_r;
  logic [rph_pkg::SBITS_W-1:0]        stored_bits_r;
  logic signed [rph_pkg::SLOPE_W-1:0] slope_q16_r;
  logic signed [rph_pkg::ICEPT_W-1:0] intercept_r;
  logic [rph_pkg::OFFSET_W-1:0]       value_offset_r;

  // Item fields.
  logic [rph_pkg::CMD_W-1:0]    in_cmd;
  logic [rph_pkg::SAMPLE_W-1:0] in_sample;
  logic [rph_pkg::SELECT_W-1:0] in_bin_select;
  logic                         in_acc;

  // Per-item state and the result waiting for the output register.
  logic [rph_pkg::CMD_W-1:0] cmd_r;
  logic [BIN_ADDR_BITS-1:0]  used_r;
  logic [COUNT_BITS-1:0]     total_r;
  logic [COUNT_BITS-1:0]     res_value_r;
  logic [BIN_ADDR_BITS-1:0]  res_used_r;
  logic [COUNT_BITS-1:0]     out_value_r;
  logic [BIN_ADDR_BITS-1:0]  out_used_r;
  logic [COUNT_BITS-1:0]     out_total_r;
  logic                      out_tvalid_r;

  // Links to the bin pipeline and the store.
  logic                     resc_vld;
  logic [BIN_ADDR_BITS-1:0] resc_bin;
  rph_pkg::st_op_t          st_op;
  logic [BIN_ADDR_BITS-1:0] st_addr;
  rph_pkg::st_rsp_t         st_rsp;
  logic [COUNT_BITS-1:0]    st_data;

  assign in_cmd        = in_tdata[1:0];
  assign in_sample     = in_tdata[18:2];
  assign in_bin_select = in_tdata[34:19];

  // A new item enters only when the sequencer and the store are both free; a result
  // still sitting in the output register does not hold it back.
  assign in_tready = (tstate_r == T_IDLE) && st_rsp.ready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r   <= rph_pkg::MODE_BYTE;
      stored_bits_r  <= rph_pkg::SBITS_RESET;
      slope_q16_r    <= rph_pkg::SLOPE_RESET;
      intercept_r    <= '0;
      value_offset_r <= '0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        rph_pkg::REG_PIXEL_MODE:   pixel_mode_r   <= cfg_wdata[rph_pkg::MODE_W-1:0];
        rph_pkg::REG_STORED_BITS:  stored_bits_r  <= cfg_wdata[rph_pkg::SBITS_W-1:0];
        rph_pkg::REG_SLOPE_Q16:    slope_q16_r    <= cfg_wdata[rph_pkg::SLOPE_W-1:0];
        rph_pkg::REG_INTERCEPT:    intercept_r    <= cfg_wdata[rph_pkg::ICEPT_W-1:0];
        rph_pkg::REG_VALUE_OFFSET: value_offset_r <= cfg_wdata[rph_pkg::OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rph_rescale #(
    .BIN_ADDR_BITS (BIN_ADDR_BITS)
  ) u_rescale (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_mode   (pixel_mode_r),
    .stored_bits  (stored_bits_r),
    .slope_q16    (slope_q16_r),
    .intercept    (intercept_r),
    .value_offset (value_offset_r),
    .in_vld       (in_acc && (in_cmd == rph_pkg::CMD_COUNT)),
    .sample       (in_sample),
    .out_vld      (resc_vld),
    .out_bin      (resc_bin)
  );

  // Reads and clears go to the store in the accept cycle; counts go once the bin is known.
  always_comb begin
    st_op.valid = 1'b0;
    st_op.kind  = rph_pkg::OP_READ;
    st_addr     = in_bin_select[BIN_ADDR_BITS-1:0];
    if (tstate_r == T_RESC) begin
      st_op.valid = resc_vld;
      st_op.kind  = rph_pkg::OP_COUNT;
      st_addr     = resc_bin;
    end else if (in_acc && (in_cmd == rph_pkg::CMD_READ)) begin
      st_op.valid = 1'b1;
    end else if (in_acc && (in_cmd == rph_pkg::CMD_CLEAR)) begin
      st_op.valid = 1'b1;
      st_op.kind  = rph_pkg::OP_CLEAR;
    end
  end

  rph_store #(
    .BIN_ADDR_BITS (BIN_ADDR_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (st_op),
    .op_addr (st_addr),
    .rsp     (st_rsp),
    .rd_data (st_data)
  );

  // Sequencer, sample total and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tstate_r     <= T_IDLE;
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // The output register refills from T_EMIT, or empties once its item is taken.
      if ((tstate_r == T_EMIT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (tstate_r)
        T_IDLE: begin
          if (in_acc) begin
            cmd_r  <= in_cmd;
            used_r <= in_bin_select[BIN_ADDR_BITS-1:0];
            unique case (in_cmd)
              rph_pkg::CMD_CLEAR: tstate_r <= T_STORE;
              rph_pkg::CMD_COUNT: tstate_r <= T_RESC;
              rph_pkg::CMD_READ:  tstate_r <= T_STORE;
              rph_pkg::CMD_NONE: begin
                // No state change; the result reports only the running total.
                res_value_r <= '0;
                res_used_r  <= '0;
                tstate_r    <= T_EMIT;
              end
              default: tstate_r <= T_IDLE;
            endcase
          end
        end
        T_RESC: begin
          if (resc_vld) begin
            used_r   <= resc_bin;
            tstate_r <= T_STORE;
          end
        end
        T_STORE: begin
          if (st_rsp.done) begin
            unique case (cmd_r)
              rph_pkg::CMD_CLEAR: begin
                total_r     <= '0;
                res_value_r <= '0;
                res_used_r  <= '0;
              end
              rph_pkg::CMD_COUNT: begin
                total_r     <= (total_r == '1) ? total_r : total_r + 1'b1;
                res_value_r <= '0;
                res_used_r  <= used_r;
              end
              rph_pkg::CMD_READ: begin
                res_value_r <= st_data;
                res_used_r  <= used_r;
              end
              default: begin
                res_value_r <= '0;
                res_used_r  <= used_r;
              end
            endcase
            tstate_r <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_value_r  <= res_value_r;
            out_used_r   <= res_used_r;
            out_total_r  <= total_r;
            tstate_r     <= T_IDLE;
          end
        end
        default: tstate_r <= T_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {rph_pkg::TOTAL_W'(out_total_r),
                       rph_pkg::USED_W'(out_used_r),
                       rph_pkg::VALUE_W'(out_value_r)};

endmodule

`default_nettype wire

@@ dv/rph_tb_pkg.sv @@
// Scoreboard for the rescaled pixel histogram bench: it mirrors the registers, bin counts and
// sample total, works out each expected result and compares the results the block returns.
// Depends on rph_pkg.
package rph_tb_pkg;
  import rph_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [USED_W-1:0]  used;
    logic [TOTAL_W-1:0] total;
  } hist_result_t;

  class histogram_scoreboard;
    logic [MODE_W-1:0]         mode;
    logic [SBITS_W-1:0]        sbits;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICEPT_W-1:0] icept;
    logic [OFFSET_W-1:0]       offs;
    // Sparse mirror of the bin memory; a missing entry holds zero.
    logic [VALUE_W-1:0]        bin_counts [logic [USED_W-1:0]];
    logic [TOTAL_W-1:0]        total;
    hist_result_t              expected_q[$];
    int                        errors;

    function new();
      mode   = MODE_BYTE;
      sbits  = SBITS_RESET;
      slope  = SLOPE_RESET;
      icept  = '0;
      offs   = '0;
      total  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PIXEL_MODE:   mode  = data[MODE_W-1:0];
        REG_STORED_BITS:  sbits = data[SBITS_W-1:0];
        REG_SLOPE_Q16:    slope = data[SLOPE_W-1:0];
        REG_INTERCEPT:    icept = data[ICEPT_W-1:0];
        REG_VALUE_OFFSET: offs  = data[OFFSET_W-1:0];
        default: ;
      endcase
    endfunction

    // Bin that a sample lands in under the current settings.
    function logic [USED_W-1:0] bin_of(logic [SAMPLE_W-1:0] smp);
      int     bits;
      longint s;
      longint v;
      longint top;
      if (mode != MODE_UNSIGN && mode != MODE_SIGNED) return USED_W'(smp[7:0]);
      bits = int'(sbits);
      if (bits < int'(SBITS_MIN)) bits = int'(SBITS_MIN);
      if (bits > int'(SBITS_MAX)) bits = int'(SBITS_MAX);
      if (mode == MODE_SIGNED && offs != 0) bits = int'(SBITS_FIXED);
      if (mode == MODE_UNSIGN) s = longint'(smp[15:0]);
      else s = longint'($signed(smp[15:0]));
      v = s * longint'(slope) + (longint'(icept) + longint'(offs)) * 64'sd65536;
      if (v < 0) return '0;
      top = (longint'(1) <<< bits) - 1;
      v = v >>> 16;
      if (v > top) v = top;
      return v[USED_W-1:0];
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp,
                             logic [SELECT_W-1:0] sel);
      hist_result_t r;
      logic [USED_W-1:0] b;
      r.value = '0;
      r.used  = '0;
      case (cmd)
        CMD_CLEAR: begin
          bin_counts.delete();
          total = '0;
        end
        CMD_COUNT: begin
          b = bin_of(smp);
          if (!bin_counts.exists(b)) bin_counts[b] = '0;
          if (bin_counts[b] != '1) bin_counts[b] = bin_counts[b] + 1'b1;
          if (total != '1) total = total + 1'b1;
          r.used = b;
        end
        CMD_READ: begin
          r.used  = sel;
          r.value = bin_counts.exists(sel) ? bin_counts[sel] : '0;
        end
        default: ;
      endcase
      r.total = total;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      hist_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, tdata);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      compare_field("bin_value", r.value, tdata[31:0]);
      compare_field("bin_used", 32'(r.used), 32'(tdata[47:32]));
      compare_field("sample_total", r.total, tdata[79:48]);
    endfunction
  endclass

endpackage

@@ dv/tb_rescaled_pixel_histogram.sv @@
// Testbench top for rescaled_pixel_histogram: directed corner items, then phases of random
// commands under random register settings, with random gaps on the input and output side.
// Depends on rph_pkg, rph_tb_pkg and the block itself.
module tb_rescaled_pixel_histogram;
  import rph_pkg::*;
  import rph_tb_pkg::*;

  // Reset sweep and each clear walk the whole 64K-entry store, so the run is dominated by
  // those; the limit allows for a handful of them plus long stalls on every item.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          NUM_PHASES  = 10;
  localparam int          PHASE_ITEMS = 133;
  // The spare pixel mode code, which the block treats as byte mode.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata   = '0;  // cmd[1:0], sample[18:2], bin_select[34:19]
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;        // bin_value[31:0], bin_used[47:32],
                                              // sample_total[79:48]
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata  = '0;

  histogram_scoreboard      sb;
  int unsigned              cycles     = 0;
  // When set, neither side inserts gaps, so items stream back to back.
  bit                       no_stall   = 1'b0;
  // The gap before the next item, drawn right after an accept so that in_tvalid can stay
  // high across back-to-back items without being lowered and raised in the same step.
  int                       next_gap   = 0;
  bit                       valid_held = 1'b0;
  // Bins recently counted, so that most reads hit a populated entry.
  logic [USED_W-1:0]        seen_bins[$];

  rescaled_pixel_histogram u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: alternate ready stretches with random stalls.
  initial begin : ready_gen
    int len;
    forever begin
      len = pick_gap();
      if (len != 0) begin
        out_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp,
                           input logic [SELECT_W-1:0] sel);
    repeat (next_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({sel, smp, cmd});
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, smp, sel);
    next_gap = pick_gap();
    if (next_gap != 0) in_tvalid <= 1'b0;
    valid_held = (next_gap == 0);
  endtask

  // Stop sending and wait for every outstanding result, then idle briefly as a margin.
  task automatic drain();
    if (valid_held) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    next_gap = 0;
  endtask

  // Write all five registers on consecutive cycles, only once the block is idle.
  task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [SBITS_W-1:0] bits,
                              input logic [SLOPE_W-1:0] slope, input logic [ICEPT_W-1:0] icept,
                              input logic [OFFSET_W-1:0] offs);
    logic [CFG_IDX_W-1:0]  idx  [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx  = '{REG_PIXEL_MODE, REG_STORED_BITS, REG_SLOPE_Q16, REG_INTERCEPT, REG_VALUE_OFFSET};
    vals = '{CFG_DATA_W'(mode), CFG_DATA_W'(bits), CFG_DATA_W'(slope), CFG_DATA_W'(icept),
             CFG_DATA_W'(offs)};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random settings for one phase, leaning toward the legal exponent range and toward
  // slopes that spread samples over many bins.
  task automatic random_config();
    logic [MODE_W-1:0]   mode;
    logic [SBITS_W-1:0]  bits;
    logic [SLOPE_W-1:0]  slope;
    logic [ICEPT_W-1:0]  icept;
    logic [OFFSET_W-1:0] offs;
    mode = $urandom_range(0, 3);
    bits = ($urandom_range(0, 4) == 0) ? SBITS_W'($urandom) : SBITS_W'($urandom_range(9, 16));
    case ($urandom_range(0, 3))
      0: slope = SLOPE_W'($urandom);
      1: slope = SLOPE_RESET;
      2: slope = SLOPE_W'($urandom_range(0, 32'h01FFFF));
      default: slope = SLOPE_W'(-int'($urandom_range(1, 32'h020000)));
    endcase
    case ($urandom_range(0, 2))
      0: icept = '0;
      1: icept = ICEPT_W'($urandom);
      default: icept = ICEPT_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
    case ($urandom_range(0, 3))
      0, 1: offs = '0;
      2: offs = OFFSET_W'($urandom);
      default: offs = OFFSET_W'($urandom_range(1, 3000));
    endcase
    apply_config(mode, bits, slope, icept, offs);
  endtask

  // One random command: mostly counts and reads, a few of the unused command code.
  // Clears are issued only at chosen phase starts since each one walks the whole store.
  task automatic random_item();
    int                  r;
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [SELECT_W-1:0] sel;
    r   = $urandom_range(0, 99);
    smp = SAMPLE_W'($urandom);
    sel = SELECT_W'($urandom);
    if (r < 5) cmd = CMD_NONE;
    else if (r < 40) cmd = CMD_READ;
    else cmd = CMD_COUNT;
    if (cmd == CMD_COUNT) begin
      case ($urandom_range(0, 2))
        0: ;
        1: smp = SAMPLE_W'($urandom_range(0, 1023));
        default: smp = SAMPLE_W'(-int'($urandom_range(1, 1024)));
      endcase
      seen_bins.push_back(sb.bin_of(smp));
      if (seen_bins.size() > 64) void'(seen_bins.pop_front());
    end else if (cmd == CMD_READ && seen_bins.size() != 0 && $urandom_range(0, 9) < 7) begin
      sel = seen_bins[$urandom_range(0, seen_bins.size() - 1)];
    end
    send_item(cmd, smp, sel);
  endtask

  initial begin : main
    int pause_at;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Byte mode after reset: the low byte picks the bin, upper sample bits are ignored.
    send_item(CMD_COUNT, 17'h00000, 16'h1234);
    send_item(CMD_COUNT, 17'h000FF, 16'hFFFF);
    send_item(CMD_COUNT, 17'h1FFFF, 16'h0000);
    send_item(CMD_COUNT, 17'h10000, 16'h8000);
    send_item(CMD_READ,  17'h1FFFF, 16'h0000);
    send_item(CMD_READ,  17'h00000, 16'h00FF);
    // Read of the top address, beyond any bin that byte mode can reach.
    send_item(CMD_READ,  17'h15555, 16'hFFFF);
    // The unused command changes nothing but still reports the total.
    send_item(CMD_NONE,  17'h0AAAA, 16'h5555);
    send_item(CMD_CLEAR, 17'h1FFFF, 16'hFFFF);
    send_item(CMD_READ,  17'h00000, 16'h00FF);

    // Unsigned wide mode with the full 64K bins and unity slope.
    apply_config(MODE_UNSIGN, SBITS_MAX, SLOPE_RESET, '0, '0);
    send_item(CMD_COUNT, 17'h0FFFF, 16'h0000);
    send_item(CMD_COUNT, 17'h10000, 16'h0000);
    send_item(CMD_READ,  17'h00000, 16'hFFFF);

    // Signed mode with a positive offset fixes the bin count at 4096: the most negative
    // sample falls below zero and the most positive one clamps to the top bin.
    apply_config(MODE_SIGNED, SBITS_MIN, SLOPE_RESET, '0, 15'd1);
    send_item(CMD_COUNT, 17'h08000, 16'h0000);
    send_item(CMD_COUNT, 17'h07FFF, 16'h0000);
    send_item(CMD_READ,  17'h00000, 16'd4095);

    // The spare mode code behaves as byte mode even with extreme rescale settings.
    apply_config(MODE_SPARE, '0, 24'h800000, 16'h7FFF, 15'h7FFF);
    send_item(CMD_COUNT, 17'h1ABCD, 16'h0000);

    // An exponent above the legal range clamps to 16; the most negative slope drives the
    // largest sample below zero, while a zero sample sits just under the top bin.
    apply_config(MODE_UNSIGN, 5'd31, 24'h800000, 16'h7FFF, 15'h7FFF);
    send_item(CMD_COUNT, 17'h00000, 16'h0000);
    send_item(CMD_COUNT, 17'h0FFFF, 16'h0000);
    send_item(CMD_READ,  17'h00000, 16'hFFFE);

    // Smallest bin count with the largest slope and lowest intercept.
    apply_config(MODE_SIGNED, SBITS_MIN, 24'h7FFFFF, 16'h8000, '0);
    send_item(CMD_COUNT, 17'h07FFF, 16'h0000);
    send_item(CMD_COUNT, 17'h18000, 16'h0000);
    send_item(CMD_READ,  17'h00000, 16'd511);

    // Random phases. Some start with a clear, a couple stream with no gaps at all, and
    // each one pauses once mid-way until all results are back.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) apply_config(MODE_BYTE, SBITS_RESET, SLOPE_RESET, '0, '0);
      else random_config();
      no_stall = (p == 3 || p == 7);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      if (p % 3 == 2) send_item(CMD_CLEAR, SAMPLE_W'($urandom), SELECT_W'($urandom));
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (j == pause_at) drain();
        random_item();
      end
    end

    no_stall = 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
